// ===== rtl/ari_pkg.sv =====
// ---------------------------------------------------------------------------
// ari_pkg - air refractivity shared definitions
// field widths, input limits and the fixed constants of the dispersion,
// temperature and pressure terms
// ---------------------------------------------------------------------------
package ari_pkg;

  // field widths
  localparam int WL_W = 18;
  localparam int TC_W = 15;
  localparam int PA_W = 17;
  localparam int RI_W = 24;

  // input limits
  localparam logic [WL_W-1:0]        WL_MIN = 18'd20000;
  localparam logic [WL_W-1:0]        WL_MAX = 18'd200000;
  localparam logic signed [TC_W-1:0] TC_MIN = -15'sd4000;
  localparam logic signed [TC_W-1:0] TC_MAX = 15'sd10000;
  localparam logic [PA_W-1:0]        PA_MIN = 17'd50000;
  localparam logic [PA_W-1:0]        PA_MAX = 17'd120000;

  // dispersion numerator constants, split for narrow multipliers
  localparam logic [41:0] KA    = 42'd2949810000000;  // 2949810 * 1e6
  localparam logic [20:0] KA_HI = KA[41:21];
  localparam logic [20:0] KA_LO = KA[20:0];
  localparam logic [34:0] KB    = 35'd25540000000;    // 25540 * 1e6
  localparam logic [13:0] KB_HI = KB[34:21];
  localparam logic [20:0] KB_LO = KB[20:0];
  localparam logic [7:0]  KA_POLE = 8'd146;
  localparam logic [7:0]  KB_POLE = 8'd41;
  localparam logic [43:0] L_UNIT  = 44'd10000000000;
  localparam logic [35:0] S_BASE  = 36'd6432800000;

  // temperature divisor, units of 1e-9
  localparam logic signed [15:0] TC_REF  = 16'sd1500;
  localparam logic signed [32:0] TC_COEF = 33'sd34785;
  localparam logic signed [32:0] DN_BASE = 33'sd1000000000;

  // pressure scaling
  localparam logic [16:0] P_REF   = 17'd101325;
  localparam logic [16:0] P_SCALE = 17'd100000;

  // divider geometry
  localparam int DN_W  = 31;
  localparam int DA_W  = 43;
  localparam int DB_W  = 41;
  localparam int DC_W  = 47;
  localparam int QAB_W = 35;
  localparam int QC_W  = 24;

  // environment values that ride along dispersion divider a
  typedef struct packed {
    logic [DN_W-1:0] dn;
    logic [PA_W-1:0] p;
  } env_t;

endpackage

// ===== rtl/air_refractive_index.sv =====
// ---------------------------------------------------------------------------
// air_refractive_index - refractivity of air from wavelength, temperature
// and pressure
// three-term dispersion formula, temperature divisor and pressure scaling,
// all in exact fixed point with round-to-nearest, ties upward
// ---------------------------------------------------------------------------
//
//  channel   dir  fields (lsb first)
//  s_axis    in   tdata: wavelength[17:0], temperature[32:18], pressure[49:33]
//  m_axis    out  tdata: refractivity[23:0]; tuser: input_clamped
//
//  one transfer in per cycle while the output is not stalled, one result per transfer
//  the dividers make up 35 stages for the dispersion terms
//  and 24 stages for the final quotient, plus 10 stages of products
//  rst is synchronous and clears only the valid bits
//  the whole pipe halts while a result waits on m_axis_tready; the output
//  register holds it, and s_axis_tready drops for the same cycles
//
module air_refractive_index
  import ari_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // wavelength, temperature, pressure, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // refractivity
  output logic        m_axis_tuser    // input_clamped
);

  // global advance: output slot free or being taken
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // input unpack and clamp
  logic [WL_W-1:0]        w_in;
  logic signed [TC_W-1:0] t_in;
  logic [PA_W-1:0]        p_in;
  logic [WL_W-1:0]        w_cl;
  logic signed [TC_W-1:0] t_cl;
  logic [PA_W-1:0]        p_cl;
  logic                   c_in;

  assign w_in = s_axis_tdata[17:0];
  assign t_in = s_axis_tdata[32:18];
  assign p_in = s_axis_tdata[49:33];

  always_comb begin
    w_cl = w_in;
    t_cl = t_in;
    p_cl = p_in;
    c_in = 1'b0;
    if (w_in < WL_MIN) begin
      w_cl = WL_MIN;
      c_in = 1'b1;
    end else if (w_in > WL_MAX) begin
      w_cl = WL_MAX;
      c_in = 1'b1;
    end
    if (t_in < TC_MIN) begin
      t_cl = TC_MIN;
      c_in = 1'b1;
    end else if (t_in > TC_MAX) begin
      t_cl = TC_MAX;
      c_in = 1'b1;
    end
    if (p_in < PA_MIN) begin
      p_cl = PA_MIN;
      c_in = 1'b1;
    end else if (p_in > PA_MAX) begin
      p_cl = PA_MAX;
      c_in = 1'b1;
    end
  end

  // stage valid bits ahead of and behind the dispersion dividers
  logic v0, v1, v2, v3, v4;
  logic v5, v6, v7, v8, v9;

  // stage 0: clamped inputs
  logic [WL_W-1:0]        w0;
  logic signed [TC_W-1:0] t0;
  logic [PA_W-1:0]        p0;
  logic                   c0;

  // stage 1: constant partial products, temperature divisor
  logic [38:0]     kah1, kal1;
  logic [31:0]     kbh1;
  logic [38:0]     kbl1;
  logic [25:0]     wa1;
  logic [23:0]     wb1;
  logic [DN_W-1:0] dn1;
  logic [WL_W-1:0] w1;
  logic [PA_W-1:0] p1;
  logic            c1;

  // stage 2: K*w sums and the dispersion denominators
  logic [59:0]     ka2;
  logic [52:0]     kb2;
  logic [DA_W-1:0] da2;
  logic [DB_W-1:0] db2;
  logic [WL_W-1:0] w2;
  logic [DN_W-1:0] dn2;
  logic [PA_W-1:0] p2;
  logic            c2;

  // stage 3: second round of partial products
  logic [47:0]     pah3, pal3;
  logic [44:0]     pbh3;
  logic [43:0]     pbl3;
  logic [DA_W-1:0] da3;
  logic [DB_W-1:0] db3;
  logic [DN_W-1:0] dn3;
  logic [PA_W-1:0] p3;
  logic            c3;

  // stage 4: rounded numerators
  logic [QAB_W+DA_W-1:0] na4;
  logic [QAB_W+DB_W-1:0] nb4;
  logic [DA_W-1:0]       da4;
  logic [DB_W-1:0]       db4;
  env_t                  env4;
  logic                  c4;

  logic signed [15:0] tdel;
  logic signed [32:0] dnf;
  logic [43:0]        da_full, db_full;

  assign tdel    = 16'(t0) - TC_REF;
  assign dnf     = DN_BASE + TC_COEF * 33'(tdel);
  assign da_full = 44'(wa1) * 44'(w1) - L_UNIT;
  assign db_full = 44'(wb1) * 44'(w1) - L_UNIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w0   <= w_cl;
      t0   <= t_cl;
      p0   <= p_cl;
      c0   <= c_in;

      kah1 <= 39'(KA_HI) * 39'(w0);
      kal1 <= 39'(KA_LO) * 39'(w0);
      kbh1 <= 32'(KB_HI) * 32'(w0);
      kbl1 <= 39'(KB_LO) * 39'(w0);
      wa1  <= 26'(KA_POLE) * 26'(w0);
      wb1  <= 24'(KB_POLE) * 24'(w0);
      dn1  <= dnf[DN_W-1:0];
      w1   <= w0;
      p1   <= p0;
      c1   <= c0;

      ka2  <= (60'(kah1) << 21) + 60'(kal1);
      kb2  <= (53'(kbh1) << 21) + 53'(kbl1);
      da2  <= da_full[DA_W-1:0];
      db2  <= db_full[DB_W-1:0];
      w2   <= w1;
      dn2  <= dn1;
      p2   <= p1;
      c2   <= c1;

      pah3 <= 48'(ka2[59:30]) * 48'(w2);
      pal3 <= 48'(ka2[29:0]) * 48'(w2);
      pbh3 <= 45'(kb2[52:26]) * 45'(w2);
      pbl3 <= 44'(kb2[25:0]) * 44'(w2);
      da3  <= da2;
      db3  <= db2;
      dn3  <= dn2;
      p3   <= p2;
      c3   <= c2;

      // half the divisor added up front gives round to nearest, ties up
      na4  <= ((QAB_W+DA_W)'(pah3) << 30) + (QAB_W+DA_W)'(pal3)
              + (QAB_W+DA_W)'(da3 >> 1);
      nb4  <= ((QAB_W+DB_W)'(pbh3) << 26) + (QAB_W+DB_W)'(pbl3)
              + (QAB_W+DB_W)'(db3 >> 1);
      da4  <= da3;
      db4  <= db3;
      env4 <= '{dn: dn3, p: p3};
      c4   <= c3;
    end
  end

  // dispersion terms, both 35 stages so they stay in step
  logic             va_q, vb_q;
  logic [QAB_W-1:0] qa, qb;
  env_t             env_q;
  logic             c_q;

  ari_div #(.DW(DA_W), .QW(QAB_W), .SW($bits(env_t))) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .ce       (adv),
    .in_valid (v4),
    .num      (na4),
    .den      (da4),
    .side_in  (env4),
    .out_valid(va_q),
    .quot     (qa),
    .side_out (env_q)
  );

  ari_div #(.DW(DB_W), .QW(QAB_W), .SW(1)) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .ce       (adv),
    .in_valid (v4),
    .num      (nb4),
    .den      (db4),
    .side_in  (c4),
    .out_valid(vb_q),
    .quot     (qb),
    .side_out (c_q)
  );

  // stage 5: reference refractivity and full divisor
  logic [35:0]     s5;
  logic [DC_W-1:0] den5;
  logic [PA_W-1:0] p5;
  logic            c5;

  // stage 6: s * p partial products
  logic [34:0]     xh6, xl6;
  logic [DC_W-1:0] den6;
  logic            c6;

  // stage 7: s * p
  logic [52:0]     sp7;
  logic [DC_W-1:0] den7;
  logic            c7;

  // stage 8: times 1e5, partial products
  logic [43:0]     mh8;
  logic [42:0]     ml8;
  logic [DC_W-1:0] den8;
  logic            c8;

  // stage 9: rounded final numerator
  logic [QC_W+DC_W-1:0] x9;
  logic [DC_W-1:0]      den9;
  logic                 c9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (adv) begin
      v5 <= va_q;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5   <= S_BASE + 36'(qa) + 36'(qb);
      den5 <= DC_W'(P_REF) * DC_W'(env_q.dn);
      p5   <= env_q.p;
      c5   <= c_q;

      xh6  <= 35'(s5[35:18]) * 35'(p5);
      xl6  <= 35'(s5[17:0]) * 35'(p5);
      den6 <= den5;
      c6   <= c5;

      sp7  <= (53'(xh6) << 18) + 53'(xl6);
      den7 <= den6;
      c7   <= c6;

      mh8  <= 44'(sp7[52:26]) * 44'(P_SCALE);
      ml8  <= 43'(sp7[25:0]) * 43'(P_SCALE);
      den8 <= den7;
      c8   <= c7;

      x9   <= ((QC_W+DC_W)'(mh8) << 26) + (QC_W+DC_W)'(ml8)
              + (QC_W+DC_W)'(den8 >> 1);
      den9 <= den8;
      c9   <= c8;
    end
  end

  // final quotient; its last stage is the output register
  ari_div #(.DW(DC_W), .QW(QC_W), .SW(1)) u_div_c (
    .clk      (clk),
    .rst      (rst),
    .ce       (adv),
    .in_valid (v9),
    .num      (x9),
    .den      (den9),
    .side_in  (c9),
    .out_valid(m_axis_tvalid),
    .quot     (m_axis_tdata),
    .side_out (m_axis_tuser)
  );

  // both dispersion dividers must hold the same item
  a_div_lockstep : assert property (@(posedge clk) disable iff (rst)
    va_q == vb_q)
    else $error("dispersion dividers out of step");

  // a waiting result must stall the input side
  a_stall_input : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // clamped inputs always give a positive refractivity
  a_result_pos : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata != '0))
    else $error("zero refractivity");

endmodule

// ===== rtl/ari_div.sv =====
// ---------------------------------------------------------------------------
// ari_div - pipelined restoring divider
// one quotient bit per stage, QW stages, sideband carried alongside
// ---------------------------------------------------------------------------
module ari_div #(
  parameter int DW = 43,
  parameter int QW = 35,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_valid,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  input  logic [SW-1:0]    side_in,
  output logic             out_valid,
  output logic [QW-1:0]    quot,
  output logic [SW-1:0]    side_out
);

  logic          v   [QW+1];
  logic [QW-1:0] qn  [QW+1];
  logic [SW-1:0] sd  [QW+1];
  logic [DW-1:0] rem [QW];
  logic [DW-1:0] dv  [QW];

  assign v[0]   = in_valid;
  assign qn[0]  = num[QW-1:0];
  assign sd[0]  = side_in;
  assign rem[0] = num[QW+DW-1:QW];
  assign dv[0]  = den;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        qbit;

    assign trial = {rem[k], qn[k][QW-1]};
    assign diff  = trial - {1'b0, dv[k]};
    assign qbit  = ~diff[DW];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (ce) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        if (QW > 1) begin
          qn[k+1] <= {qn[k][QW-2:0], qbit};
        end else begin
          qn[k+1] <= QW'(qbit);
        end
        sd[k+1] <= sd[k];
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[k+1] <= qbit ? diff[DW-1:0] : trial[DW-1:0];
          dv[k+1]  <= dv[k];
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = qn[QW];
  assign side_out  = sd[QW];

endmodule
